[rtl/core/ohrb_pkg.sv]
// ----------------------------------------------------------------------------
// ohrb_pkg
// Shared types and constants for the offline hysteresis rule bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ohrb_pkg;

  localparam int RULES       = 8;
  localparam int RULE_IDX_W  = 3;
  localparam int RULE_CNT_W  = 4;
  localparam int GRACE_W     = 20;
  localparam int THR_W       = 32;
  localparam int PIN_W       = 8;
  localparam int STATE_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [PIN_W-1:0] PIN_NONE = 8'd255;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_DISCONNECT = 3'd1,
    ACT_RECONNECT  = 3'd2,
    ACT_SERVER_ACK = 3'd3,
    ACT_ESTOP      = 3'd4,
    ACT_SAMPLE     = 3'd5,
    ACT_OVERRIDE   = 3'd6,
    ACT_LOAD_RULE  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_DRIVE    = 2'd1,
    CMD_SAFE_ALL = 2'd2
  } cmd_kind_e;

  // Encoding of the reported link mode.
  typedef enum logic [1:0] {
    MCODE_ONLINE       = 2'd0,
    MCODE_DISCONNECTED = 2'd1,
    MCODE_OFFLINE      = 2'd2,
    MCODE_RECONNECTING = 2'd3
  } mode_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_COUNT  = 2'd0,
    CFG_GRACE_TICKS = 2'd1,
    CFG_ACT_READY   = 2'd2
  } cfg_idx_e;

  // Rule flag bit positions.
  localparam int FLAG_ENABLED   = 0;
  localparam int FLAG_CALIB     = 1;
  localparam int FLAG_STATE_SET = 2;
  localparam int FLAG_INIT_ON   = 3;

  typedef struct packed {
    action_e                  action;
    logic [RULE_IDX_W-1:0]    rule_index;
    logic signed [THR_W-1:0]  sensor_value;
    logic                     value_valid;
    logic [PIN_W-1:0]         actuator_id;
    logic [STATE_W-1:0]       actuator_states;
    logic signed [THR_W-1:0]  thr_activate_below;
    logic signed [THR_W-1:0]  thr_deactivate_above;
    logic signed [THR_W-1:0]  thr_activate_above;
    logic signed [THR_W-1:0]  thr_deactivate_below;
    logic [3:0]               rule_flags;
  } in_item_t;

  typedef struct packed {
    cmd_kind_e        command_kind;
    logic [PIN_W-1:0] command_actuator;
    logic             command_on;
    mode_code_e       mode_now;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/ohrb_cfg_if.sv]
// ----------------------------------------------------------------------------
// ohrb_cfg_if
// Register write channel: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohrb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ohrb_pkg::CFG_IDX_W-1:0]   index;
  logic [ohrb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/ohrb_in_if.sv]
// ----------------------------------------------------------------------------
// ohrb_in_if
// Request channel carrying one event, sample or rule load.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohrb_in_if;
  logic               valid;
  logic               ready;
  ohrb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/ohrb_out_if.sv]
// ----------------------------------------------------------------------------
// ohrb_out_if
// Result channel carrying one actuator command and the link mode.
// ----------------------------------------------------------------------------
`default_nettype none

interface ohrb_out_if;
  logic                valid;
  logic                ready;
  ohrb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/offline_hysteresis_rule_bank.sv]
// ----------------------------------------------------------------------------
// offline_hysteresis_rule_bank
// Link-loss failsafe controller with a bank of hysteresis on/off rules.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one request per event, sensor sample, override or rule load.
//   out_o  : exactly one result per request: actuator command and link mode.
//   cfg_i  : register writes (rule count, grace ticks, actuators ready);
//            always ready, write only while no request is in flight.
// Pipeline: a request accepted on in_i is registered in the input register,
//   evaluated, and written to the result register that drives out_o. The
//   block takes one request per cycle while out_o is not stalled; the
//   rule table is eight flop entries all updated in one pass between the
//   input register and the result register.
// Stall: the result register holds while out_o.ready is low; the input
//   register still takes one more request, then in_i.ready drops until the
//   result is taken.
// Reset: link mode online, grace counter zero, all rules disabled and
//   inactive, rule count 0, grace ticks 30000, actuators ready 1. No
//   clearing pass; the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module offline_hysteresis_rule_bank (
  input  wire         clk_i,
  input  wire         rst_ni,
  ohrb_cfg_if.sink    cfg_i,
  ohrb_in_if.sink     in_i,
  ohrb_out_if.source  out_o
);
  import ohrb_pkg::*;

  typedef enum logic [3:0] {
    MODE_ONLINE       = 4'b0001,
    MODE_DISCONNECTED = 4'b0010,
    MODE_OFFLINE      = 4'b0100,
    MODE_RECONNECTING = 4'b1000
  } mode_e;

  // configuration
  logic [RULE_CNT_W-1:0] rule_count_q;
  logic [GRACE_W-1:0]    grace_ticks_q;
  logic                  act_ready_q;

  // pipeline
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      advance, fire;

  // link state
  mode_e              mode_q, mode_d;
  logic [GRACE_W-1:0] grace_cnt_q, grace_cnt_d;

  // rule bank
  logic signed [THR_W-1:0] thr_q [RULES][4];
  logic [PIN_W-1:0]        pin_q [RULES];
  logic [RULES-1:0]        en_q, cal_q, active_q, ovr_q;
  logic [RULES-1:0]        en_d, cal_d, active_d, ovr_d;
  logic                    load_we;

  // work signals
  logic [RULE_CNT_W-1:0]   n_used;
  logic [RULE_IDX_W-1:0]   idx;
  logic signed [THR_W-1:0] val;
  logic [GRACE_W-1:0]      grace_inc;
  logic                    cur, nxt;
  logic                    heat_en, cool_en;
  logic                    rule_in_use;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q  <= '0;
      grace_ticks_q <= GRACE_W'(30000);
      act_ready_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_RULE_COUNT:  rule_count_q  <= cfg_i.data[RULE_CNT_W-1:0];
        CFG_GRACE_TICKS: grace_ticks_q <= cfg_i.data[GRACE_W-1:0];
        CFG_ACT_READY:   act_ready_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.valid && in_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  function automatic mode_code_e mode_code(mode_e m);
    mode_code_e c;
    case (m)
      MODE_ONLINE:       c = MCODE_ONLINE;
      MODE_DISCONNECTED: c = MCODE_DISCONNECTED;
      MODE_OFFLINE:      c = MCODE_OFFLINE;
      MODE_RECONNECTING: c = MCODE_RECONNECTING;
      default:           c = MCODE_ONLINE;
    endcase
    return c;
  endfunction

  assign n_used = (rule_count_q > RULE_CNT_W'(RULES)) ? RULE_CNT_W'(RULES) : rule_count_q;
  assign idx    = s1_item_q.rule_index;
  assign val    = $signed(s1_item_q.sensor_value);
  assign rule_in_use = ({1'b0, idx} < n_used);
  assign grace_inc   = (grace_cnt_q == '1) ? grace_cnt_q : grace_cnt_q + GRACE_W'(1);

  // Hysteresis decision; heating then cooling, both from the old flag.
  always_comb begin
    cur     = active_q[idx];
    heat_en = (thr_q[idx][0] != '0) || (thr_q[idx][1] != '0);
    cool_en = (thr_q[idx][2] != '0) || (thr_q[idx][3] != '0);
    nxt     = cur;
    if (heat_en) begin
      if (!cur && (val < thr_q[idx][0])) nxt = 1'b1;
      if (cur && (val > thr_q[idx][1]))  nxt = 1'b0;
    end
    if (cool_en) begin
      if (!cur && (val > thr_q[idx][2])) nxt = 1'b1;
      if (cur && (val < thr_q[idx][3]))  nxt = 1'b0;
    end
  end

  always_comb begin
    mode_d      = mode_q;
    grace_cnt_d = grace_cnt_q;
    en_d        = en_q;
    cal_d       = cal_q;
    active_d    = active_q;
    ovr_d       = ovr_q;
    load_we     = 1'b0;
    out_item_d  = '{command_kind: CMD_NONE, command_actuator: '0,
                    command_on: 1'b0, mode_now: MCODE_ONLINE};

    case (s1_item_q.action)
      ACT_TICK: begin
        if (mode_q == MODE_DISCONNECTED) begin
          grace_cnt_d = grace_inc;
          if (grace_inc >= grace_ticks_q) begin
            mode_d = MODE_OFFLINE;
            if ((n_used != '0) && act_ready_q) begin
              for (int i = 0; i < RULES; i++) begin
                if ((RULE_CNT_W'(i) < n_used) && en_q[i] && (pin_q[i] != PIN_NONE)) begin
                  active_d[i] = (i < STATE_W) ? s1_item_q.actuator_states[3'(i)] : 1'b0;
                end
              end
            end
            if ((n_used == '0) && act_ready_q) begin
              out_item_d.command_kind = CMD_SAFE_ALL;
            end
          end
        end
      end
      ACT_DISCONNECT: begin
        if (mode_q == MODE_ONLINE) begin
          mode_d      = MODE_DISCONNECTED;
          grace_cnt_d = '0;
        end
      end
      ACT_RECONNECT: begin
        if (mode_q == MODE_OFFLINE) begin
          mode_d = MODE_RECONNECTING;
        end else if (mode_q == MODE_DISCONNECTED) begin
          mode_d      = MODE_ONLINE;
          grace_cnt_d = '0;
        end
      end
      ACT_SERVER_ACK, ACT_ESTOP: begin
        if ((s1_item_q.action == ACT_ESTOP) || (mode_q != MODE_ONLINE)) begin
          mode_d      = MODE_ONLINE;
          grace_cnt_d = '0;
        end
        // flags clear on estop, or on ack out of offline/reconnecting
        if ((s1_item_q.action == ACT_ESTOP) || (mode_q == MODE_OFFLINE) ||
            (mode_q == MODE_RECONNECTING)) begin
          for (int i = 0; i < RULES; i++) begin
            if (RULE_CNT_W'(i) < n_used) begin
              active_d[i] = 1'b0;
              ovr_d[i]    = 1'b0;
            end
          end
        end
      end
      ACT_SAMPLE: begin
        if (rule_in_use && en_q[idx] && !ovr_q[idx]) begin
          if (cal_q[idx]) begin
            if (active_q[idx]) begin
              active_d[idx]                 = 1'b0;
              out_item_d.command_kind       = CMD_DRIVE;
              out_item_d.command_actuator   = pin_q[idx];
            end
          end else if (s1_item_q.value_valid && (nxt != cur)) begin
            active_d[idx]               = nxt;
            out_item_d.command_kind     = CMD_DRIVE;
            out_item_d.command_actuator = pin_q[idx];
            out_item_d.command_on       = nxt;
          end
        end
      end
      ACT_OVERRIDE: begin
        for (int i = 0; i < RULES; i++) begin
          if ((RULE_CNT_W'(i) < n_used) && (pin_q[i] == s1_item_q.actuator_id)) begin
            ovr_d[i] = 1'b1;
          end
        end
      end
      ACT_LOAD_RULE: begin
        if ({1'b0, idx} < RULE_CNT_W'(RULES)) begin
          load_we    = 1'b1;
          en_d[idx]  = s1_item_q.rule_flags[FLAG_ENABLED];
          cal_d[idx] = s1_item_q.rule_flags[FLAG_CALIB];
          ovr_d[idx] = 1'b0;
          if (s1_item_q.rule_flags[FLAG_STATE_SET]) begin
            active_d[idx] = s1_item_q.rule_flags[FLAG_INIT_ON];
          end
        end
      end
      default: ;
    endcase

    out_item_d.mode_now = mode_code(mode_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ONLINE;
      grace_cnt_q <= '0;
      en_q        <= '0;
      cal_q       <= '0;
      active_q    <= '0;
      ovr_q       <= '0;
      for (int i = 0; i < RULES; i++) begin
        pin_q[i] <= PIN_NONE;
      end
    end else if (fire) begin
      mode_q      <= mode_d;
      grace_cnt_q <= grace_cnt_d;
      en_q        <= en_d;
      cal_q       <= cal_d;
      active_q    <= active_d;
      ovr_q       <= ovr_d;
      if (load_we) begin
        pin_q[idx] <= s1_item_q.actuator_id;
      end
    end
  end

  // Threshold rows only affect results for rules that have been loaded.
  always_ff @(posedge clk_i) begin
    if (fire && load_we) begin
      thr_q[idx][0] <= s1_item_q.thr_activate_below;
      thr_q[idx][1] <= s1_item_q.thr_deactivate_above;
      thr_q[idx][2] <= s1_item_q.thr_activate_above;
      thr_q[idx][3] <= s1_item_q.thr_deactivate_below;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule

`default_nettype wire

[rtl/core/ohrb_checker.sv]
// ----------------------------------------------------------------------------
// ohrb_checker
// Port-level checks for the offline hysteresis rule bank.
// ----------------------------------------------------------------------------
`default_nettype none

module ohrb_checker (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       out_valid_i,
  input  wire                       out_ready_i,
  input  wire ohrb_pkg::out_item_t  out_data_i
);
  import ohrb_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // no command means no pin and no level
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.command_kind == CMD_NONE) |->
      (out_data_i.command_actuator == '0) && !out_data_i.command_on)
    else $error("idle command carries pin or level");

  // safe-all only comes with entry to offline mode
  a_safe_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.command_kind == CMD_SAFE_ALL) |->
      (out_data_i.mode_now == MCODE_OFFLINE) && !out_data_i.command_on)
    else $error("safe-all outside offline mode");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.command_kind == CMD_NONE) ||
      (out_data_i.command_kind == CMD_DRIVE) || (out_data_i.command_kind == CMD_SAFE_ALL))
    else $error("illegal command kind");

endmodule

bind offline_hysteresis_rule_bank ohrb_checker u_ohrb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the offline hysteresis rule bank. A predictor of
// the link modes, grace timer and rule table computes the command for every
// accepted request. Results are compared field by field, in order. Phases
// vary the registers and the idle/stall pressure on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ohrb_pkg::*;

  localparam int Q_ONE       = 1 << 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 170;
  localparam logic [GRACE_W-1:0] GRACE_SAT = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  ohrb_cfg_if cfg_if ();
  ohrb_in_if  in_if ();
  ohrb_out_if out_if ();

  offline_hysteresis_rule_bank u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state
  mode_code_e         link_st;
  logic [GRACE_W-1:0] grace_cnt;
  int                 thr_bank [RULES][4];
  logic [PIN_W-1:0]   rule_pin [RULES];
  logic [1:0]         rule_kind [RULES];
  logic               rule_on [RULES];
  logic               rule_ovr [RULES];
  logic [RULE_CNT_W-1:0] reg_rule_count;
  logic [GRACE_W-1:0]    reg_grace_ticks;
  logic                  reg_act_ready;

  in_item_t  request_backlog[$];
  out_item_t commands_due[$];
  int        reqs_queued = 0;
  int        reqs_taken = 0;
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  function automatic void clear_used_flags(int unsigned n);
    for (int i = 0; i < n; i++) begin
      rule_on[i]  = 1'b0;
      rule_ovr[i] = 1'b0;
    end
  endfunction

  // Advances the predictor by one request and returns the command it causes.
  function automatic out_item_t apply_request(in_item_t r);
    out_item_t   res;
    int unsigned n;
    int          sv;
    int unsigned idx;
    logic        cur;
    logic        nxt;
    res.command_kind     = CMD_NONE;
    res.command_actuator = '0;
    res.command_on       = 1'b0;
    n   = (reg_rule_count > RULE_CNT_W'(RULES)) ? RULES : 32'(reg_rule_count);
    sv  = r.sensor_value;
    idx = 32'(r.rule_index);
    case (r.action)
      ACT_TICK: begin
        if (link_st == MCODE_DISCONNECTED) begin
          if (grace_cnt != GRACE_SAT) grace_cnt++;
          if (grace_cnt >= reg_grace_ticks) begin
            link_st = MCODE_OFFLINE;
            if (reg_act_ready) begin
              if (n == 0) res.command_kind = CMD_SAFE_ALL;
              for (int i = 0; i < n; i++)
                if (rule_kind[i][FLAG_ENABLED] && rule_pin[i] != PIN_NONE)
                  rule_on[i] = r.actuator_states[i];
            end
          end
        end
      end
      ACT_DISCONNECT: begin
        if (link_st == MCODE_ONLINE) begin
          link_st   = MCODE_DISCONNECTED;
          grace_cnt = '0;
        end
      end
      ACT_RECONNECT: begin
        if (link_st == MCODE_OFFLINE) begin
          link_st = MCODE_RECONNECTING;
        end else if (link_st == MCODE_DISCONNECTED) begin
          link_st   = MCODE_ONLINE;
          grace_cnt = '0;
        end
      end
      ACT_SERVER_ACK: begin
        if (link_st == MCODE_RECONNECTING || link_st == MCODE_OFFLINE) begin
          link_st   = MCODE_ONLINE;
          grace_cnt = '0;
          clear_used_flags(n);
        end else if (link_st == MCODE_DISCONNECTED) begin
          link_st   = MCODE_ONLINE;
          grace_cnt = '0;
        end
      end
      ACT_ESTOP: begin
        link_st   = MCODE_ONLINE;
        grace_cnt = '0;
        clear_used_flags(n);
      end
      ACT_SAMPLE: begin
        if (idx < n && rule_kind[idx][FLAG_ENABLED] && !rule_ovr[idx]) begin
          if (rule_kind[idx][FLAG_CALIB]) begin
            // calibration pending: force off, command only on a change
            if (rule_on[idx]) begin
              rule_on[idx]         = 1'b0;
              res.command_kind     = CMD_DRIVE;
              res.command_actuator = rule_pin[idx];
              res.command_on       = 1'b0;
            end
          end else if (r.value_valid) begin
            cur = rule_on[idx];
            nxt = cur;
            if (thr_bank[idx][0] != 0 || thr_bank[idx][1] != 0) begin
              if (!cur && sv < thr_bank[idx][0]) nxt = 1'b1;
              if (cur && sv > thr_bank[idx][1]) nxt = 1'b0;
            end
            // cooling pair wins; both pairs look at the old flag
            if (thr_bank[idx][2] != 0 || thr_bank[idx][3] != 0) begin
              if (!cur && sv > thr_bank[idx][2]) nxt = 1'b1;
              if (cur && sv < thr_bank[idx][3]) nxt = 1'b0;
            end
            if (nxt != cur) begin
              rule_on[idx]         = nxt;
              res.command_kind     = CMD_DRIVE;
              res.command_actuator = rule_pin[idx];
              res.command_on       = nxt;
            end
          end
        end
      end
      ACT_OVERRIDE: begin
        for (int i = 0; i < n; i++)
          if (rule_pin[i] == r.actuator_id) rule_ovr[i] = 1'b1;
      end
      default: begin
        thr_bank[idx][0] = r.thr_activate_below;
        thr_bank[idx][1] = r.thr_deactivate_above;
        thr_bank[idx][2] = r.thr_activate_above;
        thr_bank[idx][3] = r.thr_deactivate_below;
        rule_pin[idx]    = r.actuator_id;
        rule_kind[idx]   = r.rule_flags[1:0];
        if (r.rule_flags[FLAG_STATE_SET]) rule_on[idx] = r.rule_flags[FLAG_INIT_ON];
        rule_ovr[idx] = 1'b0;
      end
    endcase
    res.mode_now = link_st;
    return res;
  endfunction

  // Request builders
  function automatic in_item_t plain_item(action_e a);
    in_item_t r;
    r             = '0;
    r.action      = a;
    r.actuator_id = PIN_NONE;
    return r;
  endfunction

  function automatic in_item_t load_item(int idx, int ab, int da, int aa, int db,
                                         logic [PIN_W-1:0] pin, logic [3:0] fl);
    in_item_t r;
    r                      = plain_item(ACT_LOAD_RULE);
    r.rule_index           = RULE_IDX_W'(idx);
    r.thr_activate_below   = ab;
    r.thr_deactivate_above = da;
    r.thr_activate_above   = aa;
    r.thr_deactivate_below = db;
    r.actuator_id          = pin;
    r.rule_flags           = fl;
    return r;
  endfunction

  function automatic in_item_t sample_item(int idx, int v, logic fresh);
    in_item_t r;
    r              = plain_item(ACT_SAMPLE);
    r.rule_index   = RULE_IDX_W'(idx);
    r.sensor_value = v;
    r.value_valid  = fresh;
    return r;
  endfunction

  // Q16.16 value within +/-4.0, where the shaped thresholds live
  function automatic int near_value();
    return int'($urandom_range(8 << 16)) - (4 << 16);
  endfunction

  function automatic logic [PIN_W-1:0] likely_pin();
    int p;
    p = $urandom_range(9);
    if (p < 5) return PIN_W'(p + 1);
    if (p < 8) return PIN_NONE;
    return PIN_W'($urandom_range(255));
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    int       pick;
    int       h;
    r.action               = action_e'($urandom_range(7));
    r.rule_index           = RULE_IDX_W'($urandom_range(7));
    r.sensor_value         = $urandom;
    r.value_valid          = 1'($urandom_range(1));
    r.actuator_id          = PIN_W'($urandom_range(255));
    r.actuator_states      = STATE_W'($urandom_range(255));
    r.thr_activate_below   = $urandom;
    r.thr_deactivate_above = $urandom;
    r.thr_activate_above   = $urandom;
    r.thr_deactivate_below = $urandom;
    r.rule_flags           = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.action      = ACT_SAMPLE;
      r.value_valid = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 75) r.sensor_value = near_value();
    end else if (pick < 52) begin
      r.action                   = ACT_LOAD_RULE;
      r.actuator_id              = likely_pin();
      r.rule_flags[FLAG_ENABLED] = ($urandom_range(9) != 0);
      r.rule_flags[FLAG_CALIB]   = ($urandom_range(99) < 15);
      if ($urandom_range(99) < 85) begin
        h = $urandom_range(9);
        if (h < 2) begin
          r.thr_activate_below   = 0;
          r.thr_deactivate_above = 0;
        end else if (h == 2) begin
          r.thr_activate_below   = 0;
          r.thr_deactivate_above = near_value();
        end else begin
          r.thr_activate_below   = near_value();
          r.thr_deactivate_above = r.thr_activate_below + int'($urandom_range(2 << 16));
        end
        h = $urandom_range(9);
        if (h < 3) begin
          r.thr_activate_above   = 0;
          r.thr_deactivate_below = 0;
        end else if (h == 3) begin
          r.thr_activate_above   = near_value();
          r.thr_deactivate_below = 0;
        end else begin
          r.thr_activate_above   = near_value();
          r.thr_deactivate_below = r.thr_activate_above - int'($urandom_range(2 << 16));
        end
      end
    end else if (pick < 75) begin
      r.action = ACT_TICK;
    end else if (pick < 81) begin
      r.action = ACT_DISCONNECT;
    end else if (pick < 87) begin
      r.action = ACT_RECONNECT;
    end else if (pick < 93) begin
      r.action = ACT_SERVER_ACK;
    end else if (pick < 96) begin
      r.action      = ACT_OVERRIDE;
      r.actuator_id = likely_pin();
    end else if (pick < 98) begin
      r.action = ACT_ESTOP;
    end
    return r;
  endfunction

  function automatic void queue_request(in_item_t r);
    request_backlog.push_back(r);
    reqs_queued++;
  endfunction

  // All three registers back to back; valid stays high between writes.
  task automatic write_config(input logic [RULE_CNT_W-1:0] rc, input logic [GRACE_W-1:0] gt,
                              input logic ar);
    logic [CFG_DATA_W-1:0] vals [3];
    int                    k;
    vals[0] = CFG_DATA_W'(rc);
    vals[1] = CFG_DATA_W'(gt);
    vals[2] = CFG_DATA_W'(ar);
    for (k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_idx_e'(k);
      cfg_if.data  <= vals[k];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid    <= 1'b0;
    reg_rule_count  = rc;
    reg_grace_ticks = gt;
    reg_act_ready   = ar;
  endtask

  task automatic wait_drained();
    while (reqs_taken != reqs_queued || commands_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        commands_due.push_back(apply_request(in_if.data));
        reqs_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= request_backlog.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (commands_due.size() == 0) begin
          $error("result with no request pending: kind %0d pin %0d on %0d mode %0d",
                 got.command_kind, got.command_actuator, got.command_on, got.mode_now);
          mismatches++;
        end else begin
          want = commands_due.pop_front();
          if (got.command_kind !== want.command_kind) begin
            $error("command_kind: expected %0d, got %0d", want.command_kind, got.command_kind);
            mismatches++;
          end
          if (got.command_actuator !== want.command_actuator) begin
            $error("command_actuator: expected %0d, got %0d",
                   want.command_actuator, got.command_actuator);
            mismatches++;
          end
          if (got.command_on !== want.command_on) begin
            $error("command_on: expected %0d, got %0d", want.command_on, got.command_on);
            mismatches++;
          end
          if (got.mode_now !== want.mode_now) begin
            $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
            mismatches++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: no handshake of any kind for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_item_t          r;
    int                ph;
    int                k;
    logic [RULE_CNT_W-1:0] ph_count [PHASES];
    logic [GRACE_W-1:0]    ph_grace [PHASES];
    logic                  ph_ready [PHASES];
    int                    ph_idle  [4];
    int                    ph_stall [4];

    ph_count = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8, 4'd1};
    ph_grace = '{20'd1, 20'd3, 20'd0, 20'hFFFFF, 20'd2, 20'd1, 20'd4, 20'd2};
    ph_ready = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    ph_idle  = '{0, 76, 0, 8};
    ph_stall = '{0, 0, 76, 8};

    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data      = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_RULE_COUNT;
    cfg_if.data     = '0;

    link_st         = MCODE_ONLINE;
    grace_cnt       = '0;
    reg_rule_count  = '0;
    reg_grace_ticks = 20'd30000;
    reg_act_ready   = 1'b1;
    for (k = 0; k < RULES; k++) begin
      thr_bank[k]  = '{0, 0, 0, 0};
      rule_pin[k]  = PIN_NONE;
      rule_kind[k] = '0;
      rule_on[k]   = 1'b0;
      rule_ovr[k]  = 1'b0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one of each rule kind, stale and edge readings, full link cycle
    write_config(4'd8, 20'd2, 1'b1);
    queue_request(load_item(0, -Q_ONE, Q_ONE, 0, 0, 8'd10, 4'b0001));
    queue_request(load_item(1, 0, 0, 2 * Q_ONE, Q_ONE, 8'd11, 4'b1101));
    queue_request(load_item(2, 0, 0, 0, 0, 8'd12, 4'b1111));
    queue_request(load_item(3, -Q_ONE, Q_ONE, 5 * Q_ONE, 4 * Q_ONE, PIN_NONE, 4'b0001));
    queue_request(sample_item(0, -2 * Q_ONE, 1'b1));
    queue_request(sample_item(0, 2 * Q_ONE, 1'b0));
    queue_request(sample_item(0, 2 * Q_ONE, 1'b1));
    queue_request(sample_item(1, Q_ONE / 2, 1'b1));
    queue_request(sample_item(2, 0, 1'b0));
    queue_request(sample_item(3, 32'h7FFF_FFFF, 1'b1));
    queue_request(sample_item(5, -2 * Q_ONE, 1'b1));
    queue_request(sample_item(0, 32'h8000_0000, 1'b1));
    r = plain_item(ACT_OVERRIDE);
    r.actuator_id = 8'd10;
    queue_request(r);
    queue_request(sample_item(0, 2 * Q_ONE, 1'b1));
    queue_request(plain_item(ACT_DISCONNECT));
    queue_request(plain_item(ACT_TICK));
    r = plain_item(ACT_TICK);
    r.actuator_states = 8'hA5;
    queue_request(r);
    queue_request(plain_item(ACT_RECONNECT));
    queue_request(plain_item(ACT_SERVER_ACK));
    queue_request(plain_item(ACT_TICK));
    queue_request(plain_item(ACT_DISCONNECT));
    queue_request(plain_item(ACT_ESTOP));
    queue_request(plain_item(ACT_RECONNECT));
    queue_request(plain_item(ACT_SERVER_ACK));
    queue_request(load_item(7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            PIN_NONE, 4'b0000));
    wait_drained();

    // Random phases; each ends with the sender held until all results are in
    for (ph = 0; ph < PHASES; ph++) begin
      write_config(ph_count[ph], ph_grace[ph], ph_ready[ph]);
      send_idle_pct  = ph_idle[ph % 4];
      recv_stall_pct = ph_stall[ph % 4];
      for (k = 0; k < PHASE_REQS; k++) queue_request(random_request());
      wait_drained();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

[offline_hysteresis_rule_bank.f]
rtl/core/ohrb_pkg.sv
rtl/core/ohrb_cfg_if.sv
rtl/core/ohrb_in_if.sv
rtl/core/ohrb_out_if.sv
rtl/core/offline_hysteresis_rule_bank.sv
rtl/core/ohrb_checker.sv
tb/sv/testbench.sv
